[design/u16dec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16dec_pkg
// Shared constants and types for the UTF-16LE stream decoder.
// ----------------------------------------------------------------------------
package u16dec_pkg;

  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] HI_SUR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SUR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SUR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SUR_LAST  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;

  // What the back end emits for the current unit
  typedef enum logic [1:0] {
    K_NONE,
    K_UNIT,
    K_JOIN,
    K_END
  } cur_kind_t;

  // One queued command: optional release of a held high surrogate, then
  // at most one result for the current unit.
  typedef struct packed {
    logic       rel;
    logic [9:0] hi_bits;
    cur_kind_t  kind;
    logic [15:0] unit;
    logic       fin;
  } cmd_t;

endpackage
`default_nettype wire

[design/u16dec_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16dec_front
// Pairs bytes into 16-bit units, tracks a held high surrogate and queues
// at most one command per unit or stream end.
// ----------------------------------------------------------------------------
module u16dec_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               join_pairs,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  input  wire logic               q_ready,
  output logic                    push,
  output u16dec_pkg::cmd_t        push_cmd
);

  logic       byte_phase;
  logic [7:0] held_low_byte;
  logic       pend_valid;
  logic [9:0] pend_bits;

  logic       byte_phase_next;
  logic       pend_valid_next;
  logic [9:0] pend_bits_next;

  logic        accept;
  logic [15:0] unit;
  logic        is_hi;
  logic        is_lo;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign unit     = {in_byte, held_low_byte};
  assign is_hi    = (unit >= u16dec_pkg::HI_SUR_FIRST) && (unit <= u16dec_pkg::HI_SUR_LAST);
  assign is_lo    = (unit >= u16dec_pkg::LO_SUR_FIRST) && (unit <= u16dec_pkg::LO_SUR_LAST);

  always_comb begin
    push_cmd         = '0;
    push_cmd.hi_bits = pend_bits;
    push_cmd.unit    = unit;
    push_cmd.fin     = in_last;
    push_cmd.kind    = u16dec_pkg::K_NONE;
    byte_phase_next  = byte_phase;
    pend_valid_next  = pend_valid;
    pend_bits_next   = pend_bits;

    if (!byte_phase) begin
      byte_phase_next = 1'b1;
      if (in_last) begin
        // odd trailing byte: drop it, flush a held surrogate or mark the end
        push_cmd.rel  = pend_valid;
        push_cmd.kind = pend_valid ? u16dec_pkg::K_NONE : u16dec_pkg::K_END;
      end
    end else begin
      byte_phase_next = 1'b0;
      if (pend_valid && join_pairs && is_lo) begin
        push_cmd.kind   = u16dec_pkg::K_JOIN;
        pend_valid_next = 1'b0;
        pend_bits_next  = '0;
      end else begin
        push_cmd.rel    = pend_valid;
        pend_valid_next = 1'b0;
        pend_bits_next  = '0;
        if (join_pairs && is_hi && !in_last) begin
          pend_valid_next = 1'b1;
          pend_bits_next  = unit[9:0];
        end else begin
          push_cmd.kind = u16dec_pkg::K_UNIT;
        end
      end
    end

    if (in_last) begin
      byte_phase_next = 1'b0;
      pend_valid_next = 1'b0;
      pend_bits_next  = '0;
    end
  end

  assign push = accept && (push_cmd.rel || (push_cmd.kind != u16dec_pkg::K_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= 1'b0;
      pend_valid <= 1'b0;
      pend_bits  <= '0;
    end else if (accept) begin
      byte_phase <= byte_phase_next;
      pend_valid <= pend_valid_next;
      pend_bits  <= pend_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !byte_phase) begin
      held_low_byte <= in_byte;
    end
  end

endmodule
`default_nettype wire

[design/u16dec_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16dec_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module u16dec_queue #(
  parameter int DEPTH = u16dec_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire u16dec_pkg::cmd_t  push_cmd,
  output logic                   not_full,
  input  wire logic              pop,
  output logic                   head_valid,
  output u16dec_pkg::cmd_t       head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u16dec_pkg::cmd_t mem [DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign not_full   = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[design/u16dec_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16dec_back
// Expands queued commands into result words and holds them in the output
// register.
// ----------------------------------------------------------------------------
module u16dec_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         head_valid,
  input  wire u16dec_pkg::cmd_t             head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [u16dec_pkg::CP_W-1:0]       out_cp,
  output logic                              out_char,
  output logic                              out_last
);

  logic done_rel;
  logic done_rel_next;
  logic load;

  logic [u16dec_pkg::CP_W-1:0] res_cp;
  logic                        res_char;
  logic                        res_last;

  assign load = head_valid && (!out_valid || out_ready);

  always_comb begin
    res_cp        = '0;
    res_char      = 1'b1;
    res_last      = head.fin;
    pop           = 1'b0;
    done_rel_next = done_rel;
    if (head.rel && !done_rel) begin
      // release the held high surrogate first
      res_cp   = {5'd0, u16dec_pkg::HI_SUR_FIRST | {6'd0, head.hi_bits}};
      res_last = head.fin && (head.kind == u16dec_pkg::K_NONE);
      if (load) begin
        pop           = (head.kind == u16dec_pkg::K_NONE);
        done_rel_next = (head.kind != u16dec_pkg::K_NONE);
      end
    end else begin
      case (head.kind)
        u16dec_pkg::K_UNIT: res_cp = {5'd0, head.unit};
        u16dec_pkg::K_JOIN: res_cp = u16dec_pkg::SUPP_BASE + {1'b0, head.hi_bits, head.unit[9:0]};
        u16dec_pkg::K_END: begin
          res_cp   = '0;
          res_char = 1'b0;
        end
        default: begin
          res_cp   = '0;
          res_char = 1'b0;
        end
      endcase
      if (load) begin
        pop           = 1'b1;
        done_rel_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done_rel  <= 1'b0;
    end else begin
      done_rel <= done_rel_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cp   <= res_cp;
      out_char <= res_char;
      out_last <= res_last;
    end
  end

  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_char) |-> (out_last && (out_cp == '0)))
    else $error("bare end mark must carry last and a zero code point");

  a_cp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cp <= u16dec_pkg::CP_MAX))
    else $error("code point out of range");

  a_half_done: assert property (@(posedge clk) disable iff (rst)
    done_rel |-> (head_valid && head.rel && (head.kind != u16dec_pkg::K_NONE)))
    else $error("released surrogate without its pending unit command");

endmodule
`default_nettype wire

[design/utf16le_stream_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf16le_stream_decoder
// UTF-16LE byte stream to code point decoder with surrogate pair joining.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the command queue has room and emits at most
// one result per cycle. A byte is classified combinationally in the front end;
// every second byte (or a final byte) queues at most one command, which the
// back end turns into one result, or two when a held high surrogate is released
// ahead of the current unit. The command queue (QUEUE_DEPTH entries) lets the
// input keep streaming while the output is stalled; results leave through a
// one-deep output register, loaded from the queue head.
// join_pairs resets to 1; the user must write it only while the stream is idle,
// as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module utf16le_stream_decoder #(
  parameter int QUEUE_DEPTH = u16dec_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: join_pairs
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  // input bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic        s_axis_tlast,   // last_byte
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [0:0]       m_axis_tuser,   // [0] char_valid
  output logic             m_axis_tlast    // last
);

  logic join_pairs;

  logic              push;
  u16dec_pkg::cmd_t  push_cmd;
  logic              q_ready;
  logic              pop;
  logic              head_valid;
  u16dec_pkg::cmd_t  head;

  logic [u16dec_pkg::CP_W-1:0] out_cp;
  logic                        out_char;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      join_pairs <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      join_pairs <= cfg_data;
    end
  end

  u16dec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .join_pairs (join_pairs),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .q_ready    (q_ready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  u16dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .not_full   (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  u16dec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_cp     (out_cp),
    .out_char   (out_char),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, out_cp};
  assign m_axis_tuser = out_char;

endmodule
`default_nettype wire
